>>> rtl/smv_pkg.sv
// Shared constants, types and status codes for the sample mean/variance block.
// Used by smv_accum, smv_shift_unit and sample_mean_variance; no dependencies.

package smv_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 8;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N  = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_W + LOG_N;
    localparam int SQR_W  = 2 * SAMPLE_W - 1;
    localparam int SQ_W   = SQR_W + LOG_N;
    localparam int NQ_W   = CNT_W + SQ_W;
    localparam int UNIT_W = NQ_W + FRAC_W;
    localparam int STEP_W = $clog2(UNIT_W + 1);
    localparam int DEN_W  = 2 * CNT_W;
    localparam int MQ_W   = SAMPLE_W + FRAC_W;

    // Result field widths
    localparam int MEAN_W  = 24;
    localparam int UVAR_W  = 39;
    localparam int PVAR_W  = 38;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_SINGLE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef struct packed {
        logic sq_en;
        logic add_en;
        logic clr;
    } acc_ctl_t;

endpackage

>>> rtl/smv_accum.sv
// Running count, sum and sum of squares for one set of samples.
// Depends on smv_pkg.

module smv_accum import smv_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  acc_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic        [CNT_W-1:0]    count,
    output logic signed [SUM_W-1:0]    sum,
    output logic        [SQ_W-1:0]     sumsq,
    output logic                       ovf
);

    logic        [SQR_W-1:0] sq_reg;
    logic        [CNT_W-1:0] count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic        [SQ_W-1:0]  sumsq_reg;
    logic                    ovf_reg;
    logic signed [2*SAMPLE_W-1:0] prod;

    assign prod = sample * sample;

    always_ff @(posedge aclk) begin
        if (ctl.sq_en) begin
            sq_reg <= prod[SQR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (ctl.add_en) begin
            if (count_reg < CNT_W'(MAX_SAMPLES)) begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign count = count_reg;
    assign sum   = sum_reg;
    assign sumsq = sumsq_reg;
    assign ovf   = ovf_reg;

endmodule

>>> rtl/smv_shift_unit.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on smv_pkg.

module smv_shift_unit import smv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  unit_ctl_t         ctl,
    input  logic [UNIT_W-1:0] opa,      // multiplicand or dividend
    input  logic [UNIT_W-1:0] opb,      // multiplier or divisor
    output unit_sts_t         sts,
    output logic [UNIT_W-1:0] acc_out,  // product or remainder
    output logic [UNIT_W-1:0] quo_out   // quotient
);

    unit_op_t          op_reg;
    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [UNIT_W-1:0] acc_reg, shf_reg, opnd_reg;

    logic              is_div, top_bit, borrow;
    logic [UNIT_W-1:0] x_val, y_val, acc_next, shf_next;
    logic [UNIT_W:0]   addend, total;

    // One adder serves both operations
    always_comb begin
        is_div  = (op_reg == OP_DIV);
        top_bit = shf_reg[UNIT_W-1];
        x_val   = {acc_reg[UNIT_W-2:0], is_div & top_bit};
        y_val   = (is_div || top_bit) ? opnd_reg : '0;
        addend  = is_div ? ~{1'b0, y_val} : {1'b0, y_val};
        total   = {1'b0, x_val} + addend + {{UNIT_W{1'b0}}, is_div};
        borrow  = total[UNIT_W];
        if (is_div) begin
            acc_next = borrow ? x_val : total[UNIT_W-1:0];
            shf_next = {shf_reg[UNIT_W-2:0], ~borrow};
        end else begin
            acc_next = total[UNIT_W-1:0];
            shf_next = {shf_reg[UNIT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(UNIT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            op_reg  <= ctl.op;
            acc_reg <= '0;
            if (ctl.op == OP_DIV) begin
                shf_reg  <= opa;
                opnd_reg <= opb;
            end else begin
                shf_reg  <= opb;
                opnd_reg <= opa;
            end
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            shf_reg <= shf_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc_out  = acc_reg;
    assign quo_out  = shf_reg;

endmodule

>>> rtl/sample_mean_variance.sv
// Top level of the sample mean/variance block: sequencer, result register.
// Depends on smv_pkg, smv_accum and smv_shift_unit.
//
// Usage:
//   Samples enter on the s_ channel, one item per handshake; s_tlast marks the
//   final sample of a set. Each sample is accepted, squared and then added to
//   the sums, so s_tready stays low while an item is squared and added.
//   On a marked sample the sequencer runs seven operations on the shared
//   bit-serial multiply/divide unit: N*Q, S*S, N*N, N*(N-1), then the mean,
//   population and unbiased divisions. Each is a start, the unit's steps at
//   one bit per cycle, and a done strobe. With the output register free,
//   m_tvalid rises from the final state once the last division is done.
//   The result sits in an output register on the m_ channel; the block takes
//   new samples while it waits. If the receiver stalls, the next set's result
//   waits in its final state, with s_tready low, until the register frees.
//   Samples past MAX_SAMPLES are dropped and the result reports status 2.
//   A set of one sample reports status 1 and unbiased variance 0.
//   Reset (aresetn low, synchronous) clears the accumulators, the sequencer
//   and the output valid.

module sample_mean_variance import smv_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,   // [15:0] sample
    input  logic          s_tlast,   // last_sample
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // [23:0] mean_scaled, [62:24] unbiased_var_scaled,
                                     // [100:63] population_var_scaled, [111:101] sample_count
    output logic [1:0]    m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ADD, S_NQ, S_SS, S_NN, S_NN1,
        S_DMEAN, S_DPV, S_DUV, S_OUT
    } state_t;

    localparam int CNT_LSB = MEAN_W + UVAR_W + PVAR_W;

    state_t                     state_reg;
    logic                       start_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic [NQ_W-1:0]            nq_reg, d_reg;
    logic [DEN_W-1:0]           denp_reg, denu_reg;
    logic [MQ_W-1:0]            mq_reg;
    logic                       mnz_reg;
    logic [PVAR_W-1:0]          pvar_reg;
    logic [UVAR_W-1:0]          uvar_reg;

    logic                       m_tvalid_reg;
    logic [111:0]               m_tdata_reg;
    logic [STAT_W-1:0]          m_tuser_reg;

    acc_ctl_t                   acc_ctl;
    logic [CNT_W-1:0]           acc_count;
    logic signed [SUM_W-1:0]    acc_sum;
    logic [SQ_W-1:0]            acc_sumsq;
    logic                       acc_ovf;

    unit_ctl_t                  unit_ctl;
    unit_sts_t                  unit_sts;
    logic [UNIT_W-1:0]          unit_opa, unit_opb, unit_acc, unit_quo;

    logic [SUM_W-1:0]           mag;
    logic                       load_out;
    logic [MQ_W:0]              mean_mag, mean_full;
    logic [MEAN_W-1:0]          mean_val;
    logic [UVAR_W-1:0]          uvar_val;
    logic [PVAR_W-1:0]          pvar_val;
    logic [STAT_W-1:0]          stat_val;

    smv_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .sample  (sample_reg),
        .count   (acc_count),
        .sum     (acc_sum),
        .sumsq   (acc_sumsq),
        .ovf     (acc_ovf)
    );

    smv_shift_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (unit_ctl),
        .opa     (unit_opa),
        .opb     (unit_opb),
        .sts     (unit_sts),
        .acc_out (unit_acc),
        .quo_out (unit_quo)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        acc_ctl.sq_en  = (state_reg == S_SQ);
        acc_ctl.add_en = (state_reg == S_ADD);
        acc_ctl.clr    = load_out;
    end

    // Magnitude of the running sum; the sign is applied to the mean at the end
    assign mag = acc_sum[SUM_W-1] ? SUM_W'(0) - $unsigned(acc_sum) : $unsigned(acc_sum);

    // Operand selection for the shared unit, by sequencer step
    always_comb begin
        unit_ctl.start = start_reg;
        unit_ctl.op    = OP_MUL;
        unit_opa       = '0;
        unit_opb       = '0;
        case (state_reg)
            S_NQ: begin
                unit_opa = UNIT_W'(acc_sumsq);
                unit_opb = UNIT_W'(acc_count);
            end
            S_SS: begin
                unit_opa = UNIT_W'(mag);
                unit_opb = UNIT_W'(mag);
            end
            S_NN: begin
                unit_opa = UNIT_W'(acc_count);
                unit_opb = UNIT_W'(acc_count);
            end
            S_NN1: begin
                unit_opa = UNIT_W'(acc_count);
                unit_opb = UNIT_W'(acc_count - CNT_W'(1));
            end
            S_DMEAN: begin
                unit_ctl.op = OP_DIV;
                unit_opa    = UNIT_W'({mag, {FRAC_W{1'b0}}});
                unit_opb    = UNIT_W'(acc_count);
            end
            S_DPV: begin
                unit_ctl.op = OP_DIV;
                unit_opa    = {d_reg, {FRAC_W{1'b0}}};
                unit_opb    = UNIT_W'(denp_reg);
            end
            S_DUV: begin
                unit_ctl.op = OP_DIV;
                unit_opa    = {d_reg, {FRAC_W{1'b0}}};
                unit_opb    = UNIT_W'(denu_reg);
            end
            default: begin
                unit_ctl.op = OP_MUL;
            end
        endcase
    end

    // Result fields: floor the negative mean, zero what an empty or single set lacks
    always_comb begin
        mean_mag  = {1'b0, mq_reg} + {{MQ_W{1'b0}}, mnz_reg};
        mean_full = acc_sum[SUM_W-1] ? (MQ_W+1)'(0) - mean_mag : {1'b0, mq_reg};
        mean_val  = (acc_count == '0) ? '0 : mean_full[MEAN_W-1:0];
        pvar_val  = (acc_count == '0) ? '0 : pvar_reg;
        uvar_val  = (acc_count > CNT_W'(1)) ? uvar_reg : '0;
        if (acc_ovf) begin
            stat_val = ST_DROPPED;
        end else if (acc_count == CNT_W'(1)) begin
            stat_val = ST_SINGLE;
        end else begin
            stat_val = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        sample_reg <= s_tdata;
                        last_reg   <= s_tlast;
                        state_reg  <= S_SQ;
                    end
                end
                S_SQ: begin
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    if (last_reg) begin
                        state_reg <= S_NQ;
                        start_reg <= 1'b1;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_NQ: begin
                    if (unit_sts.done) begin
                        nq_reg    <= unit_acc[NQ_W-1:0];
                        state_reg <= S_SS;
                        start_reg <= 1'b1;
                    end
                end
                S_SS: begin
                    if (unit_sts.done) begin
                        d_reg     <= nq_reg - unit_acc[NQ_W-1:0];
                        state_reg <= S_NN;
                        start_reg <= 1'b1;
                    end
                end
                S_NN: begin
                    if (unit_sts.done) begin
                        denp_reg  <= unit_acc[DEN_W-1:0];
                        state_reg <= S_NN1;
                        start_reg <= 1'b1;
                    end
                end
                S_NN1: begin
                    if (unit_sts.done) begin
                        denu_reg  <= unit_acc[DEN_W-1:0];
                        state_reg <= S_DMEAN;
                        start_reg <= 1'b1;
                    end
                end
                S_DMEAN: begin
                    if (unit_sts.done) begin
                        mq_reg    <= unit_quo[MQ_W-1:0];
                        mnz_reg   <= |unit_acc;
                        state_reg <= S_DPV;
                        start_reg <= 1'b1;
                    end
                end
                S_DPV: begin
                    if (unit_sts.done) begin
                        pvar_reg  <= unit_quo[PVAR_W-1:0];
                        state_reg <= S_DUV;
                        start_reg <= 1'b1;
                    end
                end
                S_DUV: begin
                    if (unit_sts.done) begin
                        uvar_reg  <= unit_quo[UVAR_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register frees, then post the item
                    if (load_out) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {COUNT_W'(acc_count), pvar_val, uvar_val, mean_val};
                        m_tuser_reg  <= stat_val;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Drop-counting must stop the count at the limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");

    // The unit finishes only while the sequencer waits on it
    a_done_in_op: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_sts.done |-> (state_reg == S_NQ || state_reg == S_SS || state_reg == S_NN ||
                           state_reg == S_NN1 || state_reg == S_DMEAN ||
                           state_reg == S_DPV || state_reg == S_DUV))
        else $error("unit done outside an operation step");

    // No sample is taken while the shared unit is running
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !unit_sts.busy)
        else $error("sample accepted while unit busy");

    // A single-sample status goes with a count of one and zero unbiased variance
    a_single_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_SINGLE) |->
            (m_tdata[CNT_LSB +: COUNT_W] == COUNT_W'(1) &&
             m_tdata[MEAN_W +: UVAR_W] == '0))
        else $error("single-sample result inconsistent");

endmodule
